/* rtl/core/wmm_pkg.sv */
package wmm_pkg;

    localparam int OP_W       = 1;
    localparam int LEVEL_W    = 3;
    localparam int WAVE_W     = 4;
    localparam int INDEX_W    = 8;
    localparam int VALUE_W    = 16;
    localparam int PHASE_W    = 32;
    localparam int POSITION_W = 17;
    localparam int INC_W      = 32;
    localparam int SAMPLE_W   = 16;
    localparam int MIPS_W     = 4;
    localparam int WEIGHT_W   = 16;

    localparam logic [OP_W-1:0] OP_LOAD = 1'b0;
    localparam logic [OP_W-1:0] OP_READ = 1'b1;

    typedef logic [WEIGHT_W-1:0] log_frac_t [256];

    function automatic log_frac_t build_log_frac();
        log_frac_t   tbl;
        logic [63:0] v;
        logic [15:0] r;
        for (int m = 0; m < 256; m++)
        begin
            v = 64'(256 + m) << 22;
            r = '0;
            for (int b = 15; b >= 0; b--)
            begin
                v = (v * v) >> 30;
                if (v >= (64'd2 << 30))
                begin
                    v = v >> 1;
                    r[b] = 1'b1;
                end
            end
            tbl[m] = r;
        end
        return tbl;
    endfunction

    localparam log_frac_t LOG_FRAC = build_log_frac();

endpackage

/* rtl/core/wmm_req_if.sv */
interface wmm_req_if;
    import wmm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [OP_W-1:0]       operation;
    logic [LEVEL_W-1:0]    load_level;
    logic [WAVE_W-1:0]     load_wave;
    logic [INDEX_W-1:0]    load_index;
    logic signed [VALUE_W-1:0] load_value;
    logic [PHASE_W-1:0]    phase;
    logic [POSITION_W-1:0] position;
    logic [INC_W-1:0]      phase_increment;

    modport source (output valid, operation, load_level, load_wave, load_index, load_value,
                    phase, position, phase_increment, input ready);
    modport sink (input valid, operation, load_level, load_wave, load_index, load_value,
                  phase, position, phase_increment, output ready);
endinterface

/* rtl/core/wmm_rsp_if.sv */
interface wmm_rsp_if;
    import wmm_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, sample, input ready);
    modport sink (input valid, sample, output ready);
endinterface

/* rtl/core/wmm_cfg_if.sv */
interface wmm_cfg_if;
    import wmm_pkg::*;
    logic              valid;
    logic              ready;
    logic [MIPS_W-1:0] mips_in_use;

    modport source (output valid, mips_in_use, input ready);
    modport sink (input valid, mips_in_use, output ready);
endinterface

/* rtl/core/wmm_ram.sv */
module wmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else if (en)
        begin
            rdata <= mem[addr];
        end
    end
endmodule

/* rtl/core/wavetable_mip_morph_readout_top.sv */
// Channel | Dir | Payload
// req     | in  | operation, load_level, load_wave, load_index, load_value, phase,
//         |     | position, phase_increment
// rsp     | out | sample (read transfers only)
// cfg     | in  | mips_in_use
//
// A read makes 8 accesses to the single table port (4 when one mip level applies),
// a load at most one write, a read with no levels loaded none; decode of the next transfer overlaps.
// After the table reads, a read result is registered through the sample, wave and level blend stages into rsp.
// Reset clears control state only; the table is undefined until loaded.
// A held rsp freezes the read pipeline once a result is waiting behind it.
module wavetable_mip_morph_readout_top #(
    parameter int WAVE_SIZE   = 256,
    parameter int NUM_WAVES   = 16,
    parameter int NUM_LEVELS  = 8,
    parameter int SAMPLE_BITS = 16
) (
    input logic         clk,
    input logic         rst_n,
    wmm_req_if.sink     req,
    wmm_rsp_if.source   rsp,
    wmm_cfg_if.sink     cfg
);
    import wmm_pkg::*;

    localparam int IB   = $clog2(WAVE_SIZE);
    localparam int WB   = $clog2(NUM_WAVES);
    localparam int LB   = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int AW   = LB + WB + IB;
    localparam int SB   = SAMPLE_BITS;
    localparam int XW   = PHASE_W + IB + 1;
    localparam int SW   = POSITION_W + WB + 1;
    localparam int RW   = INC_W + IB + 1;
    localparam int LVW  = $clog2(RW - INC_W + 1) + 1;

    typedef logic signed [SB-1:0] smp_t;

    function automatic smp_t blend(smp_t a, smp_t b, logic [WEIGHT_W-1:0] w);
        logic signed [SB:0]            diff;
        logic signed [SB+WEIGHT_W+2:0] prod;
        diff = (SB+1)'(b) - (SB+1)'(a);
        prod = (SB+WEIGHT_W+3)'(diff) * $signed({1'b0, w}) + (SB+WEIGHT_W+3)'(32768);
        return SB'((SB+WEIGHT_W+3)'(a) + (prod >>> WEIGHT_W));
    endfunction

    logic [MIPS_W-1:0] mips_reg;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mips_reg <= '0;
        end
        else if (cfg.valid)
        begin
            mips_reg <= cfg.mips_in_use;
        end
    end

    // decode stage 0: capture
    logic                  d0_vld_reg;
    logic [OP_W-1:0]       d0_op_reg;
    logic [LEVEL_W-1:0]    d0_lvl_reg;
    logic [WAVE_W-1:0]     d0_wave_reg;
    logic [INDEX_W-1:0]    d0_idx_reg;
    logic signed [VALUE_W-1:0] d0_val_reg;
    logic [PHASE_W-1:0]    d0_phase_reg;
    logic [POSITION_W-1:0] d0_pos_reg;
    logic [INC_W-1:0]      d0_inc_reg;

    // decode stage 1: products
    logic            d1_vld_reg;
    logic            d1_load_reg;
    logic            d1_wok_reg;
    logic [AW-1:0]   d1_addr_reg;
    smp_t            d1_val_reg;
    logic [XW-1:0]   d1_x_reg;
    logic [SW-1:0]   d1_s_reg;
    logic [RW-1:0]   d1_r_reg;

    logic d0_move;
    logic d1_move;
    logic stall;

    assign d0_move   = d0_vld_reg && (!d1_vld_reg || d1_move);
    assign req.ready = !d0_vld_reg || d0_move;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d0_vld_reg <= 1'b0;
            d1_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                d0_vld_reg <= req.valid;
            end
            if (d0_move)
            begin
                d1_vld_reg <= 1'b1;
            end
            else if (d1_move)
            begin
                d1_vld_reg <= 1'b0;
            end
        end
    end

    logic signed [24:0] ext_val;
    smp_t               sat_val;
    always_comb
    begin
        ext_val = 25'(d0_val_reg);
        if (ext_val > 25'sd0 + ((25'sd1 <<< (SB-1)) - 25'sd1))
        begin
            sat_val = smp_t'((25'sd1 <<< (SB-1)) - 25'sd1);
        end
        else if (ext_val < -(25'sd1 <<< (SB-1)))
        begin
            sat_val = smp_t'(-(25'sd1 <<< (SB-1)));
        end
        else
        begin
            sat_val = smp_t'(ext_val);
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            d0_op_reg    <= req.operation;
            d0_lvl_reg   <= req.load_level;
            d0_wave_reg  <= req.load_wave;
            d0_idx_reg   <= req.load_index;
            d0_val_reg   <= req.load_value;
            d0_phase_reg <= req.phase;
            d0_pos_reg   <= req.position;
            d0_inc_reg   <= req.phase_increment;
        end
        if (d0_move)
        begin
            d1_load_reg <= (d0_op_reg == OP_LOAD);
            d1_wok_reg  <= (32'(d0_lvl_reg) < NUM_LEVELS) && (32'(d0_wave_reg) < NUM_WAVES)
                           && (32'(d0_idx_reg) < WAVE_SIZE);
            d1_addr_reg <= {LB'(d0_lvl_reg), WB'(d0_wave_reg), IB'(d0_idx_reg)};
            d1_val_reg  <= sat_val;
            d1_x_reg    <= XW'(d0_phase_reg) * XW'(WAVE_SIZE);
            d1_s_reg    <= SW'(d0_pos_reg) * SW'(NUM_WAVES - 1);
            d1_r_reg    <= RW'(d0_inc_reg) * RW'(WAVE_SIZE);
        end
    end

    // handoff decode
    logic [MIPS_W-1:0]   mips_c;
    logic [IB-1:0]       h_i1, h_i2;
    logic [WB-1:0]       h_w1, h_w2;
    logic [WEIGHT_W-1:0] h_t, h_wt, h_frac;
    logic [LVW-1:0]      h_lvl;
    logic [7:0]          h_fidx;
    logic [MIPS_W:0]     h_l1, h_l2;
    logic [SW-1:0]       h_wi;

    always_comb
    begin
        mips_c = (32'(mips_reg) > NUM_LEVELS) ? MIPS_W'(NUM_LEVELS) : mips_reg;
        h_i1   = IB'(d1_x_reg >> PHASE_W);
        h_i2   = (32'(h_i1) + 1 == WAVE_SIZE) ? '0 : IB'(h_i1 + 1'b1);
        h_t    = d1_x_reg[PHASE_W-1 -: WEIGHT_W];
        h_wi   = d1_s_reg >> WEIGHT_W;
        if (h_wi >= SW'(NUM_WAVES - 1))
        begin
            h_w1 = WB'(NUM_WAVES - 1);
            h_wt = '0;
        end
        else
        begin
            h_w1 = WB'(h_wi);
            h_wt = d1_s_reg[WEIGHT_W-1:0];
        end
        h_w2   = (32'(h_w1) + 1 < NUM_WAVES) ? WB'(h_w1 + 1'b1) : WB'(NUM_WAVES - 1);
        h_lvl  = '0;
        h_fidx = '0;
        for (int j = INC_W; j < RW; j++)
        begin
            if (d1_r_reg[j])
            begin
                h_lvl  = LVW'(j - INC_W);
                h_fidx = d1_r_reg[j-1 -: 8];
            end
        end
        h_frac = LOG_FRAC[h_fidx];
        h_l1   = (32'(h_lvl) > 32'(mips_c) - 1) ? (MIPS_W+1)'(mips_c) - 1'b1
                                                : (MIPS_W+1)'(h_lvl);
        h_l2   = (h_l1 + 1'b1 < (MIPS_W+1)'(mips_c)) ? h_l1 + 1'b1
                                                     : (MIPS_W+1)'(mips_c) - 1'b1;
    end

    // issue stage
    logic                busy_reg;
    logic [2:0]          k_reg;
    logic                load_reg;
    logic                wok_reg;
    logic                zero_reg;
    logic                single_reg;
    logic [AW-1:0]       waddr_reg;
    smp_t                wval_reg;
    logic [LB-1:0]       l1_reg, l2_reg;
    logic [WB-1:0]       w1_reg, w2_reg;
    logic [IB-1:0]       i1_reg, i2_reg;
    logic [WEIGHT_W-1:0] t_reg, wt_reg, frac_reg;

    logic last;
    logic ram_en, ram_we;
    logic [AW-1:0] ram_addr;
    smp_t ram_rdata;

    assign last    = load_reg || zero_reg || (k_reg == (single_reg ? 3'd3 : 3'd7));
    assign d1_move = d1_vld_reg && (!busy_reg || (last && !stall));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
        end
        else if (d1_move)
        begin
            busy_reg <= 1'b1;
            k_reg    <= '0;
        end
        else if (busy_reg && !stall)
        begin
            if (last)
            begin
                busy_reg <= 1'b0;
            end
            k_reg <= k_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (d1_move)
        begin
            load_reg   <= d1_load_reg;
            wok_reg    <= d1_wok_reg;
            zero_reg   <= (mips_c == '0);
            single_reg <= (h_l1 == h_l2);
            waddr_reg  <= d1_addr_reg;
            wval_reg   <= d1_val_reg;
            l1_reg     <= LB'(h_l1);
            l2_reg     <= LB'(h_l2);
            w1_reg     <= h_w1;
            w2_reg     <= h_w2;
            i1_reg     <= h_i1;
            i2_reg     <= h_i2;
            t_reg      <= h_t;
            wt_reg     <= h_wt;
            frac_reg   <= h_frac;
        end
    end

    assign ram_we   = busy_reg && load_reg && wok_reg && !stall;
    assign ram_en   = busy_reg && !load_reg && !zero_reg && !stall;
    assign ram_addr = load_reg ? waddr_reg
                               : {(k_reg[2] ? l2_reg : l1_reg), (k_reg[1] ? w2_reg : w1_reg),
                                  (k_reg[0] ? i2_reg : i1_reg)};

    wmm_ram #(
        .WIDTH (SB),
        .DEPTH (1 << AW)
    ) u_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (wval_reg),
        .rdata (ram_rdata)
    );

    // blend pipeline: samples, waves, levels
    logic                iss_vld_reg, iss_zero_reg, iss_single_reg;
    logic [2:0]          iss_k_reg;
    logic [WEIGHT_W-1:0] iss_t_reg, iss_wt_reg, iss_frac_reg;

    smp_t                a_reg;
    logic                s_vld_reg, s_zero_reg, s_single_reg;
    logic [2:0]          s_k_reg;
    smp_t                s_reg;
    logic [WEIGHT_W-1:0] s_wt_reg, s_frac_reg;

    smp_t                sw_reg;
    logic                m_vld_reg, m_single_reg;
    logic [2:0]          m_k_reg;
    smp_t                m_reg;
    logic [WEIGHT_W-1:0] m_frac_reg;

    smp_t                m1_reg;
    logic                m_final;
    logic                out_vld_reg;
    logic signed [SAMPLE_W-1:0] out_reg;
    smp_t                lvl_res;

    assign m_final = m_single_reg || m_k_reg[2];
    assign stall   = out_vld_reg && !rsp.ready && m_vld_reg && m_final;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_vld_reg <= 1'b0;
            s_vld_reg   <= 1'b0;
            m_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (!stall)
            begin
                iss_vld_reg <= busy_reg && !load_reg;
                s_vld_reg   <= iss_vld_reg && iss_k_reg[0];
                m_vld_reg   <= s_vld_reg && s_k_reg[1];
            end
            if (m_vld_reg && m_final && !stall)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        lvl_res = m_single_reg ? m_reg : blend(m1_reg, m_reg, m_frac_reg);
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            iss_k_reg      <= zero_reg ? 3'd3 : k_reg;
            iss_zero_reg   <= zero_reg;
            iss_single_reg <= single_reg || zero_reg;
            iss_t_reg      <= t_reg;
            iss_wt_reg     <= wt_reg;
            iss_frac_reg   <= frac_reg;

            if (iss_vld_reg && !iss_k_reg[0])
            begin
                a_reg <= ram_rdata;
            end
            s_k_reg      <= iss_k_reg;
            s_zero_reg   <= iss_zero_reg;
            s_single_reg <= iss_single_reg;
            s_wt_reg     <= iss_wt_reg;
            s_frac_reg   <= iss_frac_reg;
            s_reg        <= iss_zero_reg ? '0 : blend(a_reg, ram_rdata, iss_t_reg);

            if (s_vld_reg && !s_k_reg[1])
            begin
                sw_reg <= s_reg;
            end
            m_k_reg      <= s_k_reg;
            m_single_reg <= s_single_reg;
            m_frac_reg   <= s_frac_reg;
            m_reg        <= s_zero_reg ? '0 : blend(sw_reg, s_reg, s_wt_reg);

            if (m_vld_reg && !m_final)
            begin
                m1_reg <= m_reg;
            end
            if (m_vld_reg && m_final)
            begin
                if (32'(lvl_res) > 32767 && SB > SAMPLE_W)
                begin
                    out_reg <= 16'sh7fff;
                end
                else if ($signed(32'(lvl_res)) < -32768 && SB > SAMPLE_W)
                begin
                    out_reg <= -16'sh8000;
                end
                else
                begin
                    out_reg <= SAMPLE_W'(lvl_res);
                end
            end
        end
    end

    assign rsp.valid  = out_vld_reg;
    assign rsp.sample = out_reg;

endmodule

/* sim/tb_wavetable_mip_morph_readout_top.sv */
`timescale 1ns / 100ps

module tb_wavetable_mip_morph_readout_top;
    import wmm_pkg::*;

    localparam int N_LEVELS = 8;
    localparam int N_WAVES  = 16;
    localparam int N_SAMP   = 256;
    localparam int CYCLE_LIMIT = 100000;

    logic clk;
    logic rst_n;

    wmm_req_if req ();
    wmm_rsp_if rsp ();
    wmm_cfg_if cfg ();

    wavetable_mip_morph_readout_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source),
        .cfg   (cfg.sink)
    );

    typedef struct {
        logic [OP_W-1:0]       operation;
        logic [LEVEL_W-1:0]    load_level;
        logic [WAVE_W-1:0]     load_wave;
        logic [INDEX_W-1:0]    load_index;
        logic [VALUE_W-1:0]    load_value;
        logic [PHASE_W-1:0]    phase;
        logic [POSITION_W-1:0] position;
        logic [INC_W-1:0]      phase_increment;
    } wave_req_t;

    logic signed [15:0] table_model [N_LEVELS][N_WAVES][N_SAMP];
    logic [15:0]        log2_frac [256];
    int unsigned        level_count;
    logic [15:0]        expected_samples [$];

    int  errors;
    int  cycles;
    int  reads_checked;
    int  send_idle_pct;
    int  recv_stall_pct;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    task automatic report(input string what);
        errors++;
        $display("mismatch @%0t: %s", $realtime, what);
    endtask

    function automatic longint blend_q16(input longint a, input longint b, input longint w);
        longint p;
        p = (b - a) * w + 32768;
        return a + (p >>> 16);
    endfunction

    function automatic longint interp_level(input int lv, input int w1, input int w2,
                                            input int i1, input int i2,
                                            input longint t, input longint wt);
        longint a;
        longint b;
        a = blend_q16(table_model[lv][w1][i1], table_model[lv][w1][i2], t);
        b = blend_q16(table_model[lv][w2][i1], table_model[lv][w2][i2], t);
        return blend_q16(a, b, wt);
    endfunction

    function automatic logic [15:0] predict_sample(input wave_req_t it);
        int          mips;
        logic [63:0] x;
        logic [63:0] s;
        logic [63:0] r;
        int          i1, i2, w1, w2, p, lint, l1, l2;
        longint      t, wt, frac, res;
        mips = (level_count > N_LEVELS) ? N_LEVELS : level_count;
        if (mips == 0)
            return 16'd0;
        x  = 64'(it.phase) * N_SAMP;
        i1 = int'(x >> 32);
        i2 = (i1 + 1) % N_SAMP;
        t  = longint'(x[31:16]);
        s  = 64'(it.position) * (N_WAVES - 1);
        if ((s >> 16) >= N_WAVES - 1)
        begin
            w1 = N_WAVES - 1;
            wt = 0;
        end
        else
        begin
            w1 = int'(s >> 16);
            wt = longint'(s[15:0]);
        end
        w2 = (w1 + 1 < N_WAVES) ? w1 + 1 : N_WAVES - 1;
        r = 64'(it.phase_increment) * N_SAMP;
        if (r < (64'd1 << 32))
            r = 64'd1 << 32;
        p = 63;
        while (p > 32 && r[p] == 1'b0)
            p--;
        lint = p - 32;
        frac = longint'(log2_frac[(r >> (p - 8)) & 64'hFF]);
        l1 = (lint > mips - 1) ? mips - 1 : lint;
        l2 = (l1 + 1 < mips) ? l1 + 1 : mips - 1;
        res = interp_level(l1, w1, w2, i1, i2, t, wt);
        if (l1 != l2)
            res = blend_q16(res, interp_level(l2, w1, w2, i1, i2, t, wt), frac);
        if (res > 32767)
            res = 32767;
        if (res < -32768)
            res = -32768;
        return 16'(res);
    endfunction

    task automatic send_item(input wave_req_t it);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid           <= 1'b1;
        req.operation       <= it.operation;
        req.load_level      <= it.load_level;
        req.load_wave       <= it.load_wave;
        req.load_index      <= it.load_index;
        req.load_value      <= it.load_value;
        req.phase           <= it.phase;
        req.position        <= it.position;
        req.phase_increment <= it.phase_increment;
        do
            @(posedge clk);
        while (!req.ready);
        if (it.operation == OP_LOAD)
        begin
            table_model[it.load_level][it.load_wave][it.load_index] = it.load_value;
        end
        else
        begin
            expected_samples = {expected_samples, predict_sample(it)};
        end
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rsp.valid && rsp.ready)
        begin
            if (expected_samples.size() == 0)
                report($sformatf("unexpected sample %h", rsp.sample));
            else
            begin
                if (rsp.sample !== expected_samples[0])
                    report($sformatf("sample got %h want %h", rsp.sample,
                                     expected_samples[0]));
                void'(expected_samples.pop_front());
                reads_checked++;
            end
        end
    end

    always @(negedge clk)
        rsp.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);

    task automatic drain();
        req.valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_levels(input logic [MIPS_W-1:0] value);
        drain();
        cfg.valid       <= 1'b1;
        cfg.mips_in_use <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        level_count = value;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    function automatic wave_req_t make_load(input int lv, input int wv, input int ix,
                                            input logic [15:0] val);
        wave_req_t it;
        it.operation       = OP_LOAD;
        it.load_level      = LEVEL_W'(lv);
        it.load_wave       = WAVE_W'(wv);
        it.load_index      = INDEX_W'(ix);
        it.load_value      = val;
        it.phase           = $urandom;
        it.position        = POSITION_W'($urandom);
        it.phase_increment = $urandom;
        return it;
    endfunction

    function automatic wave_req_t make_read(input logic [31:0] ph, input logic [16:0] pos,
                                            input logic [31:0] inc);
        wave_req_t it;
        it.operation       = OP_READ;
        it.load_level      = LEVEL_W'($urandom);
        it.load_wave       = WAVE_W'($urandom);
        it.load_index      = INDEX_W'($urandom);
        it.load_value      = VALUE_W'($urandom);
        it.phase           = ph;
        it.position        = pos;
        it.phase_increment = inc;
        return it;
    endfunction

    function automatic logic [31:0] random_increment();
        int sh;
        sh = $urandom_range(31);
        return ($urandom >> sh) % 32'h8000_0001;
    endfunction

    // reads stay on samples 0/1, 127/128 and 255/0 and on waves 0/1 or 14/15
    function automatic wave_req_t random_read();
        logic [16:0] pos;
        logic [7:0]  i1;
        int          sel;
        sel = $urandom_range(2);
        i1  = (sel == 0) ? 8'd0 : ((sel == 1) ? 8'd127 : 8'd255);
        case ($urandom_range(3))
            0:       pos = 17'($urandom_range(4369));
            1:       pos = 17'($urandom_range(61167, 65535));
            2:       pos = 17'd65536;
            default: pos = 17'($urandom_range(65537, 131071));
        endcase
        return make_read({i1, 24'($urandom)}, pos, random_increment());
    endfunction

    task automatic test_silence();
        send_item(make_read(32'h0, 17'h0, 32'h0));
        send_item(make_read(32'hFFFF_FFFF, 17'd65536, 32'h8000_0000));
    endtask

    task automatic test_fill_table();
        logic [15:0] val;
        int          wv;
        int          ix;
        for (int l = 0; l < N_LEVELS; l++)
            for (int w = 0; w < 4; w++)
                for (int i = 0; i < 5; i++)
                begin
                    wv = (w < 2) ? w : N_WAVES - 4 + w;
                    ix = (i < 2) ? i : ((i < 4) ? i + 125 : N_SAMP - 1);
                    case ($urandom_range(7))
                        0:       val = 16'h7FFF;
                        1:       val = 16'h8000;
                        default: val = 16'($urandom);
                    endcase
                    send_item(make_load(l, wv, ix, val));
                end
    endtask

    task automatic test_directed_reads();
        send_item(make_read(32'h0, 17'h0, 32'h0));
        send_item(make_read(32'hFFFF_FFFF, 17'd65536, 32'h8000_0000));
        send_item(make_read(32'hFF00_0000, 17'h1FFFF, 32'h0100_0000));
        send_item(make_read(32'h0080_8000, 17'h0_0800, 32'h0180_0000));
        send_item(make_read(32'h7FFF_FFFF, 17'd61167, 32'h00FF_FFFF));
        send_item(make_read(32'h7FAA_AAAA, 17'h1_5555, 32'h5555_5555));
        send_item(make_read(32'h0055_5555, 17'h0_1111, 32'h2AAA_AAAA));
        send_item(make_read(32'h0000_FFFF, 17'h0FFFF, 32'h7FFF_FFFF));
    endtask

    task automatic test_extreme_loads();
        send_item(make_load(7, 15, 255, 16'h7FFF));
        send_item(make_load(0, 0, 0, 16'h8000));
        send_item(make_load(5, 10, 170, 16'hFFFF));
        send_item(make_load(2, 5, 85, 16'h0000));
        send_item(make_read(32'hFFFF_FFFF, 17'd65536, 32'h0));
    endtask

    task automatic test_random(input int n);
        wave_req_t it;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(3) == 0)
            begin
                it = make_load($urandom_range(7), $urandom_range(15), $urandom_range(255),
                               16'($urandom));
                send_item(it);
            end
            else
                send_item(random_read());
        end
    endtask

    initial
    begin
        logic [MIPS_W-1:0] lv_setting [6];
        int idle_set [4][2];
        errors = 0;
        cycles = 0;
        reads_checked = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        level_count = 0;
        for (int m = 0; m < 256; m++)
        begin
            logic [63:0] v;
            v = 64'(256 + m) << 22;
            log2_frac[m] = '0;
            for (int b = 15; b >= 0; b--)
            begin
                v = (v * v) >> 30;
                if (v >= (64'd2 << 30))
                begin
                    v = v >> 1;
                    log2_frac[m][b] = 1'b1;
                end
            end
        end
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.operation = OP_LOAD;
        req.load_level = '0;
        req.load_wave = '0;
        req.load_index = '0;
        req.load_value = '0;
        req.phase = '0;
        req.position = '0;
        req.phase_increment = '0;
        rsp.ready = 1'b1;
        cfg.valid = 1'b0;
        cfg.mips_in_use = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_silence();
        test_fill_table();
        lv_setting = '{4'd8, 4'd1, 4'd15, 4'd3, 4'd0, 4'd8};
        idle_set = '{'{0, 0}, '{59, 0}, '{0, 59}, '{38, 38}};
        for (int ph = 0; ph < 6; ph++)
        begin
            write_levels(lv_setting[ph]);
            send_idle_pct = idle_set[ph % 4][0];
            recv_stall_pct = idle_set[ph % 4][1];
            if (ph == 0)
            begin
                test_directed_reads();
                test_extreme_loads();
                drain();
            end
            test_random(70);
        end
        drain();
        $display("table corners loaded; %0d reads checked over level counts 0,1,3,8,15",
                 reads_checked);
        $display("mixed loads and reads under sender gaps and receiver stalls");
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
